>>> src/hpfm_pkg.sv
package hpfm_pkg;

	// Field widths of the sample and result words.
	localparam int SAMPLE_BITS = 12;
	localparam int TIME_BITS = 32;
	localparam int FREQ_BITS = 17;
	localparam int DIV_BITS = 16;

	// Configuration port widths and register indexes.
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_CODE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_CODE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT_MS = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_INTERVAL_MS = 2'd3;

	// Register values after reset.
	localparam logic [SAMPLE_BITS-1:0] HIGH_CODE_RST = 12'd1861;
	localparam logic [SAMPLE_BITS-1:0] LOW_CODE_RST = 12'd1490;
	localparam logic [DIV_BITS-1:0] TIMEOUT_MS_RST = 16'd3000;
	localparam logic [DIV_BITS-1:0] MIN_INTERVAL_MS_RST = 16'd20;

	// Centihertz for a period of one millisecond: the dividend of every measurement.
	localparam logic [FREQ_BITS-1:0] CENTIHZ_PER_MS = 17'd100000;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic [TIME_BITS-1:0]   time_ms;
	} in_word_t;

	typedef struct packed {
		logic [FREQ_BITS-1:0] freq_centihz;
		logic                 level;
		logic                 rising_edge;
		logic                 armed;
	} out_word_t;

endpackage

>>> src/hpfm_div.sv
module hpfm_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [hpfm_pkg::DIV_BITS-1:0]  divisor,
	output logic                           done,
	output logic [hpfm_pkg::FREQ_BITS-1:0] quotient
);
	import hpfm_pkg::*;

	localparam int CNT_BITS = $clog2(FREQ_BITS);

	logic                 busy_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [DIV_BITS-1:0]  divisor_q;
	logic [DIV_BITS-1:0]  rem_q;
	logic [FREQ_BITS-1:0] quo_q;
	logic [DIV_BITS:0]    trial;
	logic                 fits;

	// One restoring step: bring down the next dividend bit and try the divisor.
	assign trial = {rem_q, quo_q[FREQ_BITS-1]};
	assign fits = (trial >= {1'b0, divisor_q});

	// The quotient register starts with the dividend and shifts the result bits in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_BITS'(FREQ_BITS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			rem_q <= '0;
			quo_q <= CENTIHZ_PER_MS;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIV_BITS'(trial - {1'b0, divisor_q});
			end else begin
				rem_q <= trial[DIV_BITS-1:0];
			end
			quo_q <= {quo_q[FREQ_BITS-2:0], fits};
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign quotient = {quo_q[FREQ_BITS-2:0], fits};

endmodule

>>> src/hysteresis_pulse_frequency_meter.sv
// A word that needs no division goes from acceptance through the EMIT state into the
// output register; a rising edge that starts a measurement first waits in DIV for the
// bit-serial divider. No new word is taken while one is still in DIV or EMIT.
// A new word is taken while the previous result waits in the output register.
// Reset (arst_n low) clears the level, the edge time, the armed flag and the frequency,
// and returns the thresholds and time limits to their defaults.
module hysteresis_pulse_frequency_meter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  hpfm_pkg::in_word_t                item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output hpfm_pkg::out_word_t               result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hpfm_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [hpfm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import hpfm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t               state_q;
	logic [SAMPLE_BITS-1:0] high_code_q;
	logic [SAMPLE_BITS-1:0] low_code_q;
	logic [DIV_BITS-1:0]  timeout_ms_q;
	logic [DIV_BITS-1:0]  min_interval_ms_q;
	logic                 level_q;
	logic                 edge_q;
	logic                 armed_q;
	logic [TIME_BITS-1:0] last_edge_q;
	logic [FREQ_BITS-1:0] freq_q;
	logic                 result_valid_q;
	out_word_t            result_q;

	logic                 accept;
	logic                 level_next;
	logic                 edge_now;
	logic [TIME_BITS-1:0] interval;
	logic                 interval_ok;
	logic                 gap_over;
	logic                 div_start;
	logic                 div_done;
	logic [FREQ_BITS-1:0] div_quotient;
	logic                 out_free;

	assign cfg_ready = 1'b1;
	assign item_stall = (state_q != ST_IDLE);
	assign accept = item_valid && !item_stall;
	assign out_free = !result_valid_q || !result_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_code_q <= HIGH_CODE_RST;
			low_code_q <= LOW_CODE_RST;
			timeout_ms_q <= TIMEOUT_MS_RST;
			min_interval_ms_q <= MIN_INTERVAL_MS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HIGH_CODE:       high_code_q <= cfg_data[SAMPLE_BITS-1:0];
				CFG_LOW_CODE:        low_code_q <= cfg_data[SAMPLE_BITS-1:0];
				CFG_TIMEOUT_MS:      timeout_ms_q <= cfg_data[DIV_BITS-1:0];
				CFG_MIN_INTERVAL_MS: min_interval_ms_q <= cfg_data[DIV_BITS-1:0];
			endcase
		end
	end

	// Hysteresis comparator; the high test wins when both hold.
	always_comb begin
		if (item.sample > high_code_q) begin
			level_next = 1'b1;
		end else if (item.sample < low_code_q) begin
			level_next = 1'b0;
		end else begin
			level_next = level_q;
		end
	end

	assign edge_now = !level_q && level_next;

	// Wrapping interval since the last edge and its range checks.
	assign interval = item.time_ms - last_edge_q;
	assign interval_ok = (interval != '0)
		&& (interval >= TIME_BITS'(min_interval_ms_q))
		&& (interval < TIME_BITS'(timeout_ms_q));
	assign gap_over = (interval > TIME_BITS'(timeout_ms_q));
	assign div_start = accept && edge_now && armed_q && interval_ok;

	hpfm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (interval[DIV_BITS-1:0]),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Sequencer and meter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			level_q <= 1'b0;
			edge_q <= 1'b0;
			armed_q <= 1'b0;
			last_edge_q <= '0;
			freq_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						level_q <= level_next;
						edge_q <= edge_now;
						if (edge_now) begin
							last_edge_q <= item.time_ms;
							if (armed_q) begin
								if (!interval_ok) begin
									freq_q <= '0;
								end
							end else begin
								armed_q <= 1'b1;
							end
						end else if (armed_q && gap_over) begin
							freq_q <= '0;
							armed_q <= 1'b0;
						end
						state_q <= div_start ? ST_DIV : ST_EMIT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						freq_q <= div_quotient;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: holds a finished word until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			result_q.freq_centihz <= freq_q;
			result_q.level <= level_q;
			result_q.rising_edge <= edge_q;
			result_q.armed <= armed_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule
